// File: rtl/pabwf_pkg.sv
// ----------------------------------------------------------------------------
// pabwf_pkg
// Shared types and constants for the best/worst fit contiguous page allocator.
// ----------------------------------------------------------------------------
package pabwf_pkg;

  localparam int NUM_PAGES = 32;
  localparam int ID_BITS   = 8;

  localparam int OP_W    = 1;
  localparam int PID_W   = 8;
  localparam int PCNT_W  = 6;
  localparam int START_W = 5;
  localparam int FREED_W = 6;
  localparam int RUNS_W  = 5;

  localparam logic [OP_W-1:0] OP_ALLOC = 1'b0;
  localparam logic [OP_W-1:0] OP_FREE  = 1'b1;

  localparam logic FIT_WORST = 1'b0;
  localparam logic FIT_BEST  = 1'b1;

  localparam int          APB_AW         = 3;
  localparam logic        REG_FIT_POLICY = 1'b0;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [PID_W-1:0]  program_id;
    logic [PCNT_W-1:0] page_count;
  } req_t;

  typedef struct packed {
    logic               ok;
    logic [START_W-1:0] start_page;
    logic [FREED_W-1:0] pages_freed;
    logic [RUNS_W-1:0]  free_runs;
    logic               id_present;
  } rsp_t;

endpackage

// File: rtl/page_allocator_best_worst_fit_unit.sv
// ----------------------------------------------------------------------------
// page_allocator_best_worst_fit_unit
// Contiguous page allocator with best-fit or worst-fit run selection.
// ----------------------------------------------------------------------------
// Requests enter on req (valid/ready); each request gives one response on
// rsp (valid/ready). Allocate picks a free run at least page_count long,
// the largest (worst fit) or smallest (best fit), earliest on a tie, and
// marks its first pages. Free releases every page of the owner.
// Page state sits in one RAM; a request scans every page once in order,
// one page per cycle on the RAM read port, then a granted allocate
// writes page_count pages, one page per cycle, then the finish state
// loads the response register. A new request is taken as soon as the
// response register is loaded, while that response still waits. If the
// receiver stalls, a finished request waits until the response register
// is free.
// After reset the RAM is cleared one page per cycle;
// req_ready stays low until then. fit_policy resets to worst fit and may
// be written over the APB port at any time the block is idle.
// ----------------------------------------------------------------------------
module page_allocator_best_worst_fit_unit #(
  parameter int NUM_PAGES = pabwf_pkg::NUM_PAGES,
  parameter int ID_BITS   = pabwf_pkg::ID_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_ready,
  input  pabwf_pkg::req_t               req,
  output logic                          rsp_valid,
  input  logic                          rsp_ready,
  output pabwf_pkg::rsp_t               rsp,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pabwf_pkg::APB_AW-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam int AW   = $clog2(NUM_PAGES);
  localparam int PCW  = $clog2(NUM_PAGES + 1);
  localparam int KW   = $clog2(NUM_PAGES + 2);
  localparam int CMPW = (PCW > pabwf_pkg::PCNT_W) ? PCW : pabwf_pkg::PCNT_W;
  localparam int MW   = ID_BITS + 1;

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_SCAN   = 3'd2;
  localparam logic [2:0] ST_MARK   = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  logic [2:0] state;
  logic       fit_policy;

  // config port
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == pabwf_pkg::REG_FIT_POLICY);
  assign prdata = (paddr[2] == pabwf_pkg::REG_FIT_POLICY) ? 32'(fit_policy) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      fit_policy <= pabwf_pkg::FIT_WORST;
    end else if (cfg_wr) begin
      fit_policy <= pwdata[0];
    end
  end

  // request registers
  logic [pabwf_pkg::OP_W-1:0]   op;
  logic [ID_BITS-1:0]           id;
  logic [pabwf_pkg::PCNT_W-1:0] want;
  logic [ID_BITS-1:0]           req_id;

  always_comb begin
    for (int b = 0; b < ID_BITS; b++) begin
      req_id[b] = (b < pabwf_pkg::PID_W) ? req.program_id[b] : 1'b0;
    end
  end

  // page RAM: {used, owner}
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [MW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [MW-1:0] ram_rdata;

  pabwf_ram #(
    .WIDTH (MW),
    .DEPTH (NUM_PAGES)
  ) u_page_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // scan state
  logic [KW-1:0]  k;
  logic [PCW-1:0] mcnt;
  logic [AW-1:0]  clr_cnt;
  logic [PCW-1:0] run_len, run_len_next;
  logic [AW-1:0]  run_start, run_start_next;
  logic [PCW-1:0] runs, runs_next;
  logic [PCW-1:0] freed, freed_next;
  logic           present, present_next;
  logic           found, found_next;
  logic [AW-1:0]  best_start, best_start_next;
  logic [PCW-1:0] best_len, best_len_next;

  logic [KW-1:0] p;
  logic          proc_en;
  logic          p_last;
  logic          match;
  logic          used_eff;
  logic          take;
  logic          fits;

  assign p       = k - KW'(1);
  assign proc_en = (state == ST_SCAN) && (k != '0);
  assign p_last  = (p == KW'(NUM_PAGES));
  assign match   = !p_last && ram_rdata[MW-1] && (ram_rdata[ID_BITS-1:0] == id);
  assign ram_raddr = k[AW-1:0];

  always_comb begin
    run_len_next    = run_len;
    run_start_next  = run_start;
    runs_next       = runs;
    freed_next      = freed;
    present_next    = present;
    found_next      = found;
    best_start_next = best_start;
    best_len_next   = best_len;
    take            = 1'b0;
    fits            = 1'b0;
    if (p_last) begin
      used_eff = 1'b1;
    end else if (op == pabwf_pkg::OP_FREE) begin
      used_eff = ram_rdata[MW-1] && !match;
    end else begin
      used_eff = ram_rdata[MW-1];
    end
    if (proc_en) begin
      present_next = present || match;
      if (match && (op == pabwf_pkg::OP_FREE)) begin
        freed_next = freed + PCW'(1);
      end
      if (!used_eff) begin
        if (run_len == '0) begin
          run_start_next = p[AW-1:0];
        end
        run_len_next = run_len + PCW'(1);
      end else begin
        if (run_len != '0) begin
          runs_next = runs + PCW'(1);
          fits = (op == pabwf_pkg::OP_ALLOC) && (want != '0) &&
                 (CMPW'(run_len) >= CMPW'(want));
          if (fits) begin
            if (!found) begin
              take = 1'b1;
            end else if (fit_policy == pabwf_pkg::FIT_WORST) begin
              take = run_len > best_len;
            end else begin
              take = run_len < best_len;
            end
          end
          if (take) begin
            found_next      = 1'b1;
            best_start_next = run_start;
            best_len_next   = run_len;
          end
        end
        run_len_next = '0;
      end
    end
  end

  // RAM write port
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_cnt;
    ram_wdata = '0;
    unique case (state)
      ST_CLEAR: begin
        ram_we = 1'b1;
      end
      ST_SCAN: begin
        ram_we    = proc_en && match && (op == pabwf_pkg::OP_FREE);
        ram_waddr = p[AW-1:0];
      end
      ST_MARK: begin
        ram_we    = 1'b1;
        ram_waddr = best_start + mcnt[AW-1:0];
        ram_wdata = {1'b1, id};
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // response
  logic           full_take;
  logic [PCW-1:0] runs_after;
  pabwf_pkg::rsp_t rsp_next;

  assign full_take  = found && (CMPW'(best_len) == CMPW'(want));
  assign runs_after = runs - PCW'(full_take);

  always_comb begin
    rsp_next.ok          = (op == pabwf_pkg::OP_FREE) ? (freed != '0) : found;
    rsp_next.start_page  = found ? pabwf_pkg::START_W'(best_start) : '0;
    rsp_next.pages_freed = pabwf_pkg::FREED_W'(freed);
    rsp_next.free_runs   = pabwf_pkg::RUNS_W'(runs_after);
    rsp_next.id_present  = present;
  end

  assign req_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      k         <= '0;
      mcnt      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (state == ST_FINISH && (!rsp_valid || rsp_ready)) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + AW'(1);
          if (clr_cnt == AW'(NUM_PAGES - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (req_valid) begin
            state <= ST_SCAN;
            k     <= '0;
          end
        end
        ST_SCAN: begin
          k <= k + KW'(1);
          if (p_last && proc_en) begin
            mcnt  <= '0;
            state <= found_next ? ST_MARK : ST_FINISH;
          end
        end
        ST_MARK: begin
          mcnt <= mcnt + PCW'(1);
          if (CMPW'(mcnt) + CMPW'(1) == CMPW'(want)) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (!rsp_valid || rsp_ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && req_valid) begin
      op         <= req.operation;
      id         <= req_id;
      want       <= req.page_count;
      run_len    <= '0;
      run_start  <= '0;
      runs       <= '0;
      freed      <= '0;
      present    <= 1'b0;
      found      <= 1'b0;
      best_start <= '0;
      best_len   <= '0;
    end else if (proc_en) begin
      run_len    <= run_len_next;
      run_start  <= run_start_next;
      runs       <= runs_next;
      freed      <= freed_next;
      present    <= present_next;
      found      <= found_next;
      best_start <= best_start_next;
      best_len   <= best_len_next;
    end
    if (state == ST_FINISH && (!rsp_valid || rsp_ready)) begin
      rsp <= rsp_next;
    end
  end

endmodule

// File: rtl/pabwf_ram.sv
// ----------------------------------------------------------------------------
// pabwf_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module pabwf_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
